@@ rtl/fixed_point_alu_q20_assert.svh @@
// Assertion macros shared by the checker of the fixed-point ALU.
`ifndef FIXED_POINT_ALU_Q20_ASSERT_SVH
`define FIXED_POINT_ALU_Q20_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FPA_ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define FPA_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 20;

    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_DIV = 3'd1,
        OP_ADD = 3'd2,
        OP_SUB = 3'd3,
        OP_LT  = 3'd4,
        OP_LE  = 3'd5,
        OP_GT  = 3'd6,
        OP_GE  = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] value;
        t_status     status;
    } t_res;

    // Applies the sign to a wide magnitude and flags results outside 64 bits.
    function automatic t_res sign_fix(input logic hi_nz, input logic [63:0] lo,
                                      input logic neg);
        t_res r;
        logic ovf;
        if (neg) begin
            ovf = hi_nz || (lo > 64'h8000_0000_0000_0000);
        end else begin
            ovf = hi_nz || lo[63];
        end
        r.value  = neg ? (64'd0 - lo) : lo;
        r.status = ovf ? ST_OVF : ST_OK;
        return r;
    endfunction

endpackage

@@ rtl/fpa_delay.sv @@
`timescale 1ns / 1ps
module fpa_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [0:DEPTH-1];

    // Shift line that keeps paths of different depth aligned.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            r_line[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

@@ rtl/fpa_mul.sv @@
`timescale 1ns / 1ps
module fpa_mul #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic [63:0]  i_ma,
    input  logic [63:0]  i_mb,
    input  logic         i_neg,
    output fpa_pkg::t_res o_res
);
    import fpa_pkg::*;

    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic [127:0] r_sum;
    logic [1:0]   r_neg;
    t_res         r_res;
    logic [127:0] n_sum;
    logic [127:0] n_shift;

    // Stage one: four 32 by 32 partial products.
    always_ff @(posedge i_clk) begin
        r_ll     <= i_ma[31:0]  * i_mb[31:0];
        r_lh     <= i_ma[31:0]  * i_mb[63:32];
        r_hl     <= i_ma[63:32] * i_mb[31:0];
        r_hh     <= i_ma[63:32] * i_mb[63:32];
        r_neg[0] <= i_neg;
    end

    // Stage two: the partial products are summed to the full product.
    always_comb begin
        n_sum = 128'(r_ll) + (128'(r_lh) << 32) + (128'(r_hl) << 32)
              + (128'(r_hh) << 64);
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_neg[1] <= r_neg[0];
    end

    // Stage three: drop the fraction bits and apply the sign.
    always_comb begin
        n_shift = r_sum >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_res <= sign_fix(|n_shift[127:64], n_shift[63:0], r_neg[1]);
    end

    assign o_res = r_res;

endmodule

@@ rtl/fpa_div.sv @@
`timescale 1ns / 1ps
module fpa_div #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic [63:0]   i_ma,
    input  logic [63:0]   i_d,
    input  logic          i_neg,
    output fpa_pkg::t_res o_res
);
    import fpa_pkg::*;

    localparam int DW = 64 + FRAC_BITS;

    logic [63:0]   r_rem [1:DW];
    logic [DW-1:0] r_num [1:DW];
    logic [DW-1:0] r_q   [1:DW];
    logic [63:0]   r_d   [1:DW];
    logic          r_neg [1:DW];
    t_res          r_res;

    // One restoring step per stage, one quotient bit each.
    for (genvar k = 0; k < DW; k++) begin : g_step
        logic [63:0]   s_rem;
        logic [DW-1:0] s_num;
        logic [DW-1:0] s_q;
        logic [63:0]   s_d;
        logic          s_neg;
        logic [64:0]   n_trial;
        logic          n_qbit;
        logic [63:0]   n_rem;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_num = {i_ma, {FRAC_BITS{1'b0}}};
            assign s_q   = '0;
            assign s_d   = i_d;
            assign s_neg = i_neg;
        end else begin : g_next
            assign s_rem = r_rem[k];
            assign s_num = r_num[k];
            assign s_q   = r_q[k];
            assign s_d   = r_d[k];
            assign s_neg = r_neg[k];
        end

        always_comb begin
            n_trial = {s_rem, s_num[DW-1-k]};
            n_qbit  = (n_trial >= {1'b0, s_d});
            n_rem   = n_qbit ? 64'(n_trial - {1'b0, s_d}) : n_trial[63:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_num[k+1] <= s_num;
            r_q[k+1]   <= {s_q[DW-2:0], n_qbit};
            r_d[k+1]   <= s_d;
            r_neg[k+1] <= s_neg;
        end
    end

    // Final stage: sign and overflow of the quotient.
    always_ff @(posedge i_clk) begin
        r_res <= sign_fix(|r_q[DW][DW-1:64], r_q[DW][63:0], r_neg[DW]);
    end

    assign o_res = r_res;

endmodule

@@ rtl/fixed_point_alu_q20.sv @@
`timescale 1ns / 1ps
// Signed fixed-point ALU, 64-bit operands with FRAC_BITS fraction bits.
// Input: a transaction is taken at a clock edge where start is high and busy
// is low. busy is always low, so a new transaction may enter in every cycle.
// Each transaction gives exactly one result, shown on o_value and o_status for
// one cycle while o_valid is high. Results leave in the order of the inputs.
// Every operation passes the same registers: the input register, the operand
// register, the divider's 64 + FRAC_BITS stages, which resolve one quotient bit
// per stage, and its sign stage (the other paths are delayed to match), then
// the output register. Throughput is one transaction per cycle.
// Multiply uses four 32 by 32 partial products over three stages.
// Status: 0 ok, 1 overflow with the wrapped value, 2 divide by zero (value 0).
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall: it must take each result in its strobe cycle.
module fixed_point_alu_q20 #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_opcode,
    input  logic signed [63:0] i_operand_a,
    input  logic signed [63:0] i_operand_b,
    output logic               o_valid,
    output logic signed [63:0] o_value,
    output logic [1:0]         o_status
);
    import fpa_pkg::*;

    localparam int DW = 64 + FRAC_BITS;

    logic        r_a_valid;
    logic [2:0]  r_a_op;
    logic [63:0] r_a_a, r_a_b;

    logic        r_b_valid;
    logic [2:0]  r_b_op;
    logic        r_b_dz;
    logic        r_b_neg;
    logic [63:0] r_b_ma, r_b_mb;
    t_res        r_b_simple;

    t_res        n_simple;
    logic [63:0] n_sum, n_diff;

    t_res        w_mul, w_mul_d, w_div, w_simple_d;
    logic [3:0]  w_ctl_d;
    logic        w_valid_d;
    t_opcode     w_op;

    logic        r_out_valid;
    t_res        r_out;
    t_res        n_out;

    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start;
        end
        r_a_op <= i_opcode;
        r_a_a  <= i_operand_a;
        r_a_b  <= i_operand_b;
    end

    // Add, subtract and compares finish here; magnitudes for mul and div.
    always_comb begin
        n_sum  = r_a_a + r_a_b;
        n_diff = r_a_a - r_a_b;
        n_simple.status = ST_OK;
        n_simple.value  = '0;
        case (t_opcode'(r_a_op))
            OP_ADD: begin
                n_simple.value = n_sum;
                if ((~(r_a_a[63] ^ r_a_b[63])) & (r_a_a[63] ^ n_sum[63])) begin
                    n_simple.status = ST_OVF;
                end
            end
            OP_SUB: begin
                n_simple.value = n_diff;
                if ((r_a_a[63] ^ r_a_b[63]) & (r_a_a[63] ^ n_diff[63])) begin
                    n_simple.status = ST_OVF;
                end
            end
            OP_LT: n_simple.value = 64'($signed(r_a_a) < $signed(r_a_b));
            OP_LE: n_simple.value = 64'($signed(r_a_a) <= $signed(r_a_b));
            OP_GT: n_simple.value = 64'($signed(r_a_a) > $signed(r_a_b));
            OP_GE: n_simple.value = 64'($signed(r_a_a) >= $signed(r_a_b));
            default: n_simple.value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_op     <= r_a_op;
        r_b_dz     <= (r_a_b == 64'd0);
        r_b_neg    <= r_a_a[63] ^ r_a_b[63];
        r_b_ma     <= r_a_a[63] ? (64'd0 - r_a_a) : r_a_a;
        r_b_mb     <= r_a_b[63] ? (64'd0 - r_a_b) : r_a_b;
        r_b_simple <= n_simple;
    end

    fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_ma  (r_b_ma),
        .i_mb  (r_b_mb),
        .i_neg (r_b_neg),
        .o_res (w_mul)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk (i_clk),
        .i_ma  (r_b_ma),
        .i_d   (r_b_mb),
        .i_neg (r_b_neg),
        .o_res (w_div)
    );

    // Delay lines that bring every path to the divider's depth.
    fpa_delay #(.WIDTH($bits(t_res)), .DEPTH(DW - 2)) u_mul_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (w_mul), .o_data (w_mul_d)
    );

    fpa_delay #(.WIDTH($bits(t_res)), .DEPTH(DW + 1)) u_simple_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (r_b_simple), .o_data (w_simple_d)
    );

    fpa_delay #(.WIDTH(4), .DEPTH(DW + 1)) u_ctl_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data ({r_b_op, r_b_dz}),
        .o_data (w_ctl_d)
    );

    fpa_delay #(.WIDTH(1), .DEPTH(DW + 1)) u_valid_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (r_b_valid), .o_data (w_valid_d)
    );

    // Result select and output register.
    always_comb begin
        w_op = t_opcode'(w_ctl_d[3:1]);
        case (w_op)
            OP_MUL: n_out = w_mul_d;
            OP_DIV: begin
                if (w_ctl_d[0]) begin
                    n_out.value  = '0;
                    n_out.status = ST_DIV0;
                end else begin
                    n_out = w_div;
                end
            end
            default: n_out = w_simple_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_valid_d;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out.value;
    assign o_status = r_out.status;

endmodule

@@ rtl/fpa_checker.sv @@
`timescale 1ns / 1ps
`include "fixed_point_alu_q20_assert.svh"
module fpa_checker #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_opcode,
    input logic        o_valid,
    input logic [63:0] o_value,
    input logic [1:0]  o_status
);
    import fpa_pkg::*;

    localparam int LAT = FRAC_BITS + 68;

    logic w_cmp;
    logic w_div;

    // Opcode class of the transaction offered in this cycle.
    assign w_cmp = (i_opcode == OP_LT) || (i_opcode == OP_LE)
                || (i_opcode == OP_GT) || (i_opcode == OP_GE);
    assign w_div = (i_opcode == OP_DIV);

    `FPA_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy, "busy raised")
    `FPA_ASSERT_IMP(a_result_has_start, i_clk, i_rst_n, o_valid, $past(start, LAT),
        "result without a transaction at the fixed latency")
    `FPA_ASSERT_IMP(a_cmp_boolean, i_clk, i_rst_n, o_valid && $past(w_cmp, LAT),
        (o_status == ST_OK) && (o_value[63:1] == 63'd0),
        "compare result not 0 or 1 with ok status")
    `FPA_ASSERT_IMP(a_div0_only_div, i_clk, i_rst_n, o_valid && (o_status == ST_DIV0),
        $past(w_div, LAT) && (o_value == 64'd0),
        "divide-by-zero status on a non-divide or nonzero value")

endmodule

bind fixed_point_alu_q20 fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid),
    .o_value  (o_value),
    .o_status (o_status)
);
